### rtl/assert_macros.svh
// assertion helpers, sampled on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sws_pkg.sv
package sws_pkg;

  localparam int unsigned MaxSensorsDef = 8;
  localparam int unsigned TimeW         = 48;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 8;

  typedef enum logic [1:0] {
    OpSelect = 2'd0,
    OpStep   = 2'd1,
    OpClear  = 2'd2,
    OpConfig = 2'd3
  } op_e;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StNone = 2'd1;
  localparam logic [1:0] StSlot = 2'd2;

  localparam logic [1:0] ModeSleep    = 2'd0;
  localparam logic [1:0] ModeParallel = 2'd1;

  localparam logic [CfgIdxW-1:0] CfgSensorCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGasWait     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWakeOffset  = 2'd2;

  localparam logic [7:0] GasWaitRst    = 8'd120;
  localparam logic [7:0] WakeOffsetRst = 8'd10;

  typedef struct packed {
    logic [1:0]       mode;
    logic [TimeW-1:0] wake;
    logic [7:0]       hstep;
    logic [7:0]       scnt;
    logic [7:0]       hlen;
    logic [7:0]       slim;
    logic [31:0]      sleep_len;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic cap;
    logic prep;
    logic scan;
    logic next_pass;
    logic res_err;
    logic res_sel;
    logic upd;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic n_zero;
    logic slot_bad;
    logic scan_done;
    logic found;
    logic pass_sleep;
  } ctl_sts_t;

endpackage

### rtl/sws_req_if.sv
interface sws_req_if
  import sws_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [2:0]       sensor_slot;
  logic [TimeW-1:0] time_now;
  logic [7:0]       heater_step_in;
  logic [1:0]       new_mode;
  logic [7:0]       new_heater_length;
  logic [7:0]       new_scan_limit;
  logic [31:0]      new_sleep_length;

  modport source (
    output valid, opcode, sensor_slot, time_now, heater_step_in, new_mode,
           new_heater_length, new_scan_limit, new_sleep_length,
    input  ready
  );

  modport sink (
    input  valid, opcode, sensor_slot, time_now, heater_step_in, new_mode,
           new_heater_length, new_scan_limit, new_sleep_length,
    output ready
  );
endinterface

### rtl/sws_rsp_if.sv
interface sws_rsp_if
  import sws_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [3:0]       sensor_index;
  logic [TimeW-1:0] wake_time;
  logic [7:0]       heater_step_out;
  logic             entered_sleep;

  modport source (
    output valid, status, sensor_index, wake_time, heater_step_out, entered_sleep,
    input  ready
  );

  modport sink (
    input  valid, status, sensor_index, wake_time, heater_step_out, entered_sleep,
    output ready
  );
endinterface

### rtl/sensor_wakeup_scheduler.sv
// step, clear and configure: Prep, Upd, then Fin, where the result is registered;
//   a rejected request skips Upd. select: Prep then Fin on an empty table, else a
//   parallel pass, a sleep pass on no hit, then Fin; one table read per cycle per pass
// one request at a time; the next is taken the cycle after the result is registered
// reset: configuration to defaults, every entry reads as all zeros through
//   per-entry valid bits, no clearing pass
module sensor_wakeup_scheduler
  import sws_pkg::*;
#(
  parameter int unsigned MaxSensors = MaxSensorsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sws_req_if.sink             req_if,
  sws_rsp_if.source           rsp_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  sws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_if.valid),
    .in_ready_o  (req_if.ready),
    .out_valid_o (rsp_if.valid),
    .out_ready_i (rsp_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sws_dp #(
    .MaxSensors (MaxSensors)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .opcode_i            (req_if.opcode),
    .sensor_slot_i       (req_if.sensor_slot),
    .time_now_i          (req_if.time_now),
    .heater_step_in_i    (req_if.heater_step_in),
    .new_mode_i          (req_if.new_mode),
    .new_heater_length_i (req_if.new_heater_length),
    .new_scan_limit_i    (req_if.new_scan_limit),
    .new_sleep_length_i  (req_if.new_sleep_length),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .status_o            (rsp_if.status),
    .sensor_index_o      (rsp_if.sensor_index),
    .wake_time_o         (rsp_if.wake_time),
    .heater_step_out_o   (rsp_if.heater_step_out),
    .entered_sleep_o     (rsp_if.entered_sleep)
  );

endmodule

### rtl/sws_ram.sv
module sws_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sws_dp.sv
`include "assert_macros.svh"

module sws_dp
  import sws_pkg::*;
#(
  parameter int unsigned MaxSensors = MaxSensorsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [1:0]          opcode_i,
  input  logic [2:0]          sensor_slot_i,
  input  logic [TimeW-1:0]    time_now_i,
  input  logic [7:0]          heater_step_in_i,
  input  logic [1:0]          new_mode_i,
  input  logic [7:0]          new_heater_length_i,
  input  logic [7:0]          new_scan_limit_i,
  input  logic [31:0]         new_sleep_length_i,
  input  ctl_cmd_t            cmd_i,
  output ctl_sts_t            sts_o,
  output logic [1:0]          status_o,
  output logic [3:0]          sensor_index_o,
  output logic [TimeW-1:0]    wake_time_o,
  output logic [7:0]          heater_step_out_o,
  output logic                entered_sleep_o
);

  localparam int unsigned IdxW = (MaxSensors > 1) ? $clog2(MaxSensors) : 1;
  localparam int unsigned CntW = $clog2(MaxSensors + 1);

  // configuration
  logic [3:0] cnt_q;
  logic [7:0] gwait_q, off_q;

  // captured request
  op_e              op_q;
  logic [2:0]       slot_q;
  logic [TimeW-1:0] now_q;
  logic [7:0]       hin_q;
  logic [1:0]       nmode_q;
  logic [7:0]       nhlen_q, nslim_q;
  logic [31:0]      nsleep_q;

  // search state
  logic [CntW-1:0]  rd_idx_q, cmp_idx_q, found_q;
  logic             cmp_vld_q, pass_sleep_q;
  logic [TimeW-1:0] limit_q, sum_q;

  logic [MaxSensors-1:0] vld_q;
  logic                  vld_hit_q;

  // result and output registers
  logic [1:0]       res_status_q, out_status_q;
  logic [3:0]       res_idx_q, out_idx_q;
  logic [TimeW-1:0] res_wake_q, out_wake_q;
  logic [7:0]       res_hstep_q, out_hstep_q;
  logic             res_slept_q, out_slept_q;

  logic [CntW-1:0]   n;
  logic              slot_bad, scan_done, issue, hit;
  logic [1:0]        pass_mode;
  logic [IdxW-1:0]   raddr, waddr;
  logic [EntryW-1:0] ram_rdata;
  entry_t            entry, upd_e;
  logic              ram_we, slp;

  always_comb begin
    if (32'(cnt_q) > MaxSensors) begin
      n = CntW'(MaxSensors);
    end else begin
      n = CntW'(cnt_q);
    end
  end

  always_comb begin
    case (op_q)
      OpStep, OpClear: slot_bad = 32'(slot_q) >= 32'(n);
      OpConfig:        slot_bad = 32'(slot_q) >= MaxSensors;
      default:         slot_bad = 1'b0;
    endcase
  end

  assign scan_done = (rd_idx_q == n) && !cmp_vld_q;
  assign issue     = rd_idx_q != n;
  assign pass_mode = pass_sleep_q ? ModeSleep : ModeParallel;
  assign entry     = vld_hit_q ? entry_t'(ram_rdata) : '0;
  assign hit       = cmp_vld_q && (entry.mode == pass_mode) && (entry.wake < limit_q);

  assign raddr  = cmd_i.scan ? rd_idx_q[IdxW-1:0] : IdxW'(slot_q);
  assign waddr  = IdxW'(slot_q);
  assign ram_we = cmd_i.upd && (op_q != OpSelect);

  assign sts_o.op         = op_q;
  assign sts_o.n_zero     = n == '0;
  assign sts_o.slot_bad   = slot_bad;
  assign sts_o.scan_done  = scan_done;
  assign sts_o.found      = found_q != n;
  assign sts_o.pass_sleep = pass_sleep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      gwait_q <= GasWaitRst;
      off_q   <= WakeOffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSensorCount: cnt_q   <= cfg_data_i[3:0];
        CfgGasWait:     gwait_q <= cfg_data_i;
        CfgWakeOffset:  off_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q     <= op_e'(opcode_i);
      slot_q   <= sensor_slot_i;
      now_q    <= time_now_i;
      hin_q    <= heater_step_in_i;
      nmode_q  <= new_mode_i;
      nhlen_q  <= new_heater_length_i;
      nslim_q  <= new_scan_limit_i;
      nsleep_q <= new_sleep_length_i;
    end
  end

  // scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q     <= '0;
      cmp_vld_q    <= 1'b0;
      pass_sleep_q <= 1'b0;
    end else if (cmd_i.prep) begin
      rd_idx_q     <= '0;
      cmp_vld_q    <= 1'b0;
      pass_sleep_q <= 1'b0;
    end else if (cmd_i.next_pass) begin
      rd_idx_q     <= '0;
      cmp_vld_q    <= 1'b0;
      pass_sleep_q <= 1'b1;
    end else if (cmd_i.scan) begin
      cmp_vld_q <= issue;
      if (issue) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vld_hit_q <= vld_q[raddr];
    if (cmd_i.prep) begin
      limit_q <= now_q + TimeW'(off_q);
      sum_q   <= now_q + TimeW'(gwait_q);
      found_q <= n;
    end else if (cmd_i.next_pass) begin
      found_q <= n;
    end else if (cmd_i.scan) begin
      cmp_idx_q <= rd_idx_q;
      if (hit) begin
        limit_q <= entry.wake;
        found_q <= cmp_idx_q;
      end
    end
  end

  // entries never written read back as all zeros
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  sws_ram #(
    .Width (EntryW),
    .Depth (MaxSensors)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (upd_e),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic [7:0] nxt;
    logic [7:0] sc;
    upd_e = entry;
    slp   = 1'b0;
    nxt   = hin_q + 8'd1;
    sc    = entry.scnt;
    case (op_q)
      OpStep: begin
        if (nxt == entry.hlen) begin
          nxt = '0;
          sc  = entry.scnt + 8'd1;
          if (sc >= entry.slim) begin
            sc         = '0;
            upd_e.mode = ModeSleep;
            slp        = 1'b1;
          end
        end
        upd_e.hstep = nxt;
        upd_e.scnt  = sc;
        upd_e.wake  = sum_q + (slp ? TimeW'(entry.sleep_len) : '0);
      end
      OpClear: begin
        upd_e.scnt  = '0;
        upd_e.hstep = '0;
        upd_e.wake  = '0;
      end
      OpConfig: begin
        upd_e.mode      = nmode_q;
        upd_e.hlen      = nhlen_q;
        upd_e.slim      = nslim_q;
        upd_e.sleep_len = nsleep_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_err) begin
      res_status_q <= (op_q == OpSelect) ? StNone : StSlot;
      res_idx_q    <= (op_q == OpSelect) ? 4'd0 : 4'(slot_q);
      res_wake_q   <= '0;
      res_hstep_q  <= '0;
      res_slept_q  <= 1'b0;
    end else if (cmd_i.res_sel) begin
      res_status_q <= (found_q != n) ? StOk : StNone;
      res_idx_q    <= 4'(found_q);
      res_wake_q   <= (found_q != n) ? limit_q : '0;
      res_hstep_q  <= '0;
      res_slept_q  <= 1'b0;
    end else if (cmd_i.upd) begin
      res_status_q <= StOk;
      res_idx_q    <= 4'(slot_q);
      res_wake_q   <= (op_q == OpStep) ? upd_e.wake : '0;
      res_hstep_q  <= (op_q == OpStep) ? upd_e.hstep : '0;
      res_slept_q  <= slp;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_wake_q   <= res_wake_q;
      out_hstep_q  <= res_hstep_q;
      out_slept_q  <= res_slept_q;
    end
  end

  assign status_o          = out_status_q;
  assign sensor_index_o    = out_idx_q;
  assign wake_time_o       = out_wake_q;
  assign heater_step_out_o = out_hstep_q;
  assign entered_sleep_o   = out_slept_q;

  `ASSERT_IMP(a_sel_drained, cmd_i.res_sel, scan_done, "select result before scan drained")
  `ASSERT_IMP(a_cmp_range, cmp_vld_q, cmp_idx_q < n, "compare beyond entries in use")

endmodule

### rtl/sws_ctrl.sv
`include "assert_macros.svh"

module sws_ctrl
  import sws_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    StateIdle = 5'b00001,
    StatePrep = 5'b00010,
    StateScan = 5'b00100,
    StateUpd  = 5'b01000,
    StateFin  = 5'b10000
  } state_e;

  state_e   state_q, state_d;
  logic     out_vld_q, out_vld_d;
  ctl_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      StateIdle: begin
        if (in_valid_i) begin
          cmd.cap = 1'b1;
          state_d = StatePrep;
        end
      end
      StatePrep: begin
        cmd.prep = 1'b1;
        if (sts_i.op == OpSelect) begin
          if (sts_i.n_zero) begin
            cmd.res_err = 1'b1;
            state_d     = StateFin;
          end else begin
            state_d = StateScan;
          end
        end else if (sts_i.slot_bad) begin
          cmd.res_err = 1'b1;
          state_d     = StateFin;
        end else begin
          state_d = StateUpd;
        end
      end
      StateScan: begin
        cmd.scan = 1'b1;
        if (sts_i.scan_done) begin
          // parallel pass came up empty, fall back to sleeping sensors
          if (!sts_i.found && !sts_i.pass_sleep) begin
            cmd.next_pass = 1'b1;
          end else begin
            cmd.res_sel = 1'b1;
            state_d     = StateFin;
          end
        end
      end
      StateUpd: begin
        cmd.upd = 1'b1;
        state_d = StateFin;
      end
      StateFin: begin
        if (!out_vld_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = StateIdle;
        end
      end
      default: state_d = StateIdle;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = state_q == StateIdle;
  assign out_valid_o = out_vld_q;
  assign cmd_o       = cmd;

  `ASSERT_NXT(a_accept_prep, in_valid_i && in_ready_o, state_q == StatePrep, "request not started")
  `ASSERT_IMP(a_scan_select, state_q == StateScan, sts_i.op == OpSelect, "scan outside select")

endmodule

### test/sensor_wakeup_scheduler_tb.sv
module sensor_wakeup_scheduler_tb
  import sws_pkg::*;
;

  localparam int unsigned       NumPhases     = 14;
  localparam int unsigned       LongHold      = 400;
  localparam int unsigned       WatchdogLimit = 2000;
  localparam logic [TimeW-1:0]  TimeMax       = '1;
  localparam logic [1:0]        ModeOther     = 2'd2;
  localparam logic [1:0]        ModeSpare     = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused    = 2'd3;

  typedef struct packed {
    op_e              opcode;
    logic [2:0]       sensor_slot;
    logic [TimeW-1:0] time_now;
    logic [7:0]       heater_step_in;
    logic [1:0]       new_mode;
    logic [7:0]       new_heater_length;
    logic [7:0]       new_scan_limit;
    logic [31:0]      new_sleep_length;
  } sched_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       sensor_index;
    logic [TimeW-1:0] wake_time;
    logic [7:0]       heater_step_out;
    logic             entered_sleep;
  } sched_rsp_t;

  typedef enum logic {RowRequest, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    sched_req_t         req;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CfgDataW-1:0] reg_data;
    bit                 pinned;
    sched_rsp_t         want;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  sws_req_if req_bus ();
  sws_rsp_if rsp_bus ();

  sensor_wakeup_scheduler uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_if     (req_bus),
    .rsp_if     (rsp_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor copy of the scheduler state
  logic [1:0]       ent_mode  [MaxSensorsDef] = '{default: '0};
  logic [TimeW-1:0] ent_wake  [MaxSensorsDef] = '{default: '0};
  logic [7:0]       ent_hstep [MaxSensorsDef] = '{default: '0};
  logic [7:0]       ent_scans [MaxSensorsDef] = '{default: '0};
  logic [7:0]       ent_hlen  [MaxSensorsDef] = '{default: '0};
  logic [7:0]       ent_slim  [MaxSensorsDef] = '{default: '0};
  logic [31:0]      ent_sleep [MaxSensorsDef] = '{default: '0};
  logic [3:0]       cfg_count    = '0;
  logic [7:0]       cfg_gas_wait = GasWaitRst;
  logic [7:0]       cfg_offset   = WakeOffsetRst;

  sched_rsp_t       pending_results [$];
  dir_row_t         directed_rows [$];
  int unsigned      fail_count     = 0;
  int unsigned      idle_cycles    = 0;
  bit               allow_gaps     = 1'b0;
  bit               hold_request   = 1'b0;
  bit               long_hold_done = 1'b0;
  bit               drv_pinned     = 1'b0;
  sched_rsp_t       drv_want       = '0;
  logic [TimeW-1:0] sim_now        = '0;
  sched_req_t       seen_req;
  sched_rsp_t       seen_want;
  sched_rsp_t       oldest;

  function automatic int unsigned entries_in_use();
    return (cfg_count > MaxSensorsDef) ? MaxSensorsDef : cfg_count;
  endfunction

  function automatic sched_rsp_t predict_schedule(sched_req_t r);
    sched_rsp_t       res;
    int unsigned      n;
    int unsigned      found;
    logic [TimeW-1:0] lim;
    logic [TimeW-1:0] w;
    logic [7:0]       nxt;
    logic [1:0]       prio [2];
    bit               hit;
    int unsigned      s;
    res = '0;
    res.sensor_index = {1'b0, r.sensor_slot};
    n = entries_in_use();
    s = r.sensor_slot;
    prio[0] = ModeParallel;
    prio[1] = ModeSleep;
    case (r.opcode)
      OpSelect: begin
        if (n == 0) begin
          res.status = StNone;
          res.sensor_index = '0;
        end else begin
          lim = r.time_now + TimeW'(cfg_offset);
          found = n;
          hit = 1'b0;
          // parallel entries first; the sleep pass keeps the same bound
          for (int p = 0; p < 2; p++) begin
            if (!hit) begin
              for (int i = 0; i < n; i++) begin
                if (ent_mode[i] == prio[p] && ent_wake[i] < lim) begin
                  lim = ent_wake[i];
                  found = i;
                  hit = 1'b1;
                end
              end
            end
          end
          res.sensor_index = 4'(found);
          if (hit) res.wake_time = lim;
          else res.status = StNone;
        end
      end
      OpStep, OpClear: begin
        if (s >= n) begin
          res.status = StSlot;
        end else if (r.opcode == OpStep) begin
          nxt = r.heater_step_in + 8'd1;
          w = r.time_now + TimeW'(cfg_gas_wait);
          if (nxt == ent_hlen[s]) begin
            nxt = '0;
            ent_scans[s] = ent_scans[s] + 8'd1;
            if (ent_scans[s] >= ent_slim[s]) begin
              ent_scans[s] = '0;
              ent_mode[s] = ModeSleep;
              w = w + TimeW'(ent_sleep[s]);
              res.entered_sleep = 1'b1;
            end
          end
          ent_hstep[s] = nxt;
          ent_wake[s] = w;
          res.wake_time = w;
          res.heater_step_out = nxt;
        end else begin
          ent_scans[s] = '0;
          ent_hstep[s] = '0;
          ent_wake[s] = '0;
        end
      end
      default: begin
        ent_mode[s] = r.new_mode;
        ent_hlen[s] = r.new_heater_length;
        ent_slim[s] = r.new_scan_limit;
        ent_sleep[s] = r.new_sleep_length;
      end
    endcase
    return res;
  endfunction

  function automatic sched_req_t make_request();
    sched_req_t  r;
    int unsigned n;
    int unsigned pick;
    int unsigned m;
    logic [2:0]  s;
    n = entries_in_use();
    pick = $urandom_range(0, 99);
    sim_now = sim_now + TimeW'($urandom_range(0, 150));
    s = (n > 0 && $urandom_range(0, 7) != 0) ? 3'($urandom_range(0, n - 1))
                                             : 3'($urandom_range(0, 7));
    r.sensor_slot = s;
    r.time_now = ($urandom_range(0, 19) == 0) ? {16'($urandom), 32'($urandom)} : sim_now;
    r.heater_step_in = 8'($urandom);
    r.new_mode = 2'($urandom);
    r.new_heater_length = 8'($urandom);
    r.new_scan_limit = 8'($urandom);
    r.new_sleep_length = $urandom;
    if (pick < 30) begin
      r.opcode = OpSelect;
    end else if (pick < 70) begin
      r.opcode = OpStep;
      // mostly continue the stored profile, sometimes jump to its last step
      m = $urandom_range(0, 19);
      if (m < 12) r.heater_step_in = ent_hstep[s];
      else if (m < 17) r.heater_step_in = ent_hlen[s] - 8'd1;
    end else if (pick < 78) begin
      r.opcode = OpClear;
    end else begin
      r.opcode = OpConfig;
      m = $urandom_range(0, 19);
      r.new_mode = (m < 9) ? ModeSleep : (m < 18) ? ModeParallel :
                   (m == 18) ? ModeOther : ModeSpare;
      if ($urandom_range(0, 9) != 0) r.new_heater_length = 8'($urandom_range(1, 4));
      if ($urandom_range(0, 9) != 0) r.new_scan_limit = 8'($urandom_range(0, 3));
      if ($urandom_range(0, 7) != 0) r.new_sleep_length = $urandom_range(0, 500);
    end
    return r;
  endfunction

  function automatic dir_row_t req_row(op_e op, logic [2:0] slot, logic [TimeW-1:0] now,
                                       logic [7:0] hs, logic [1:0] md, logic [7:0] hl,
                                       logic [7:0] sl, logic [31:0] sleep_len);
    dir_row_t row;
    row.kind = RowRequest;
    row.req = '{op, slot, now, hs, md, hl, sl, sleep_len};
    row.reg_idx = '0;
    row.reg_data = '0;
    row.pinned = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    dir_row_t row;
    row = req_row(OpSelect, '0, '0, '0, '0, '0, '0, '0);
    row.kind = RowWrite;
    row.reg_idx = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic dir_row_t pin(dir_row_t row, logic [1:0] st, logic [3:0] idx);
    row.pinned = 1'b1;
    row.want = '{st, idx, '0, '0, 1'b0};
    return row;
  endfunction

  task automatic compare_field(string name, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_idx_i = idx;
    cfg_data_i = data;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_drained();
    req_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_item(sched_req_t r, bit pinned, sched_rsp_t want);
    int unsigned gap;
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.opcode = r.opcode;
    req_bus.sensor_slot = r.sensor_slot;
    req_bus.time_now = r.time_now;
    req_bus.heater_step_in = r.heater_step_in;
    req_bus.new_mode = r.new_mode;
    req_bus.new_heater_length = r.new_heater_length;
    req_bus.new_scan_limit = r.new_scan_limit;
    req_bus.new_sleep_length = r.new_sleep_length;
    drv_pinned = pinned;
    drv_want = want;
    req_bus.valid = 1'b1;
    do @(posedge clk_i); while (!req_bus.ready);
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // results are checked before the new request is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSensorCount: cfg_count = cfg_data_i[3:0];
          CfgGasWait:     cfg_gas_wait = cfg_data_i;
          CfgWakeOffset:  cfg_offset = cfg_data_i;
          default: ;
        endcase
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        idle_cycles = 0;
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: status %0h index %0h",
                 rsp_bus.status, rsp_bus.sensor_index);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          compare_field("status", TimeW'(oldest.status), TimeW'(rsp_bus.status));
          compare_field("sensor_index", TimeW'(oldest.sensor_index),
                        TimeW'(rsp_bus.sensor_index));
          compare_field("wake_time", oldest.wake_time, rsp_bus.wake_time);
          compare_field("heater_step_out", TimeW'(oldest.heater_step_out),
                        TimeW'(rsp_bus.heater_step_out));
          compare_field("entered_sleep", TimeW'(oldest.entered_sleep),
                        TimeW'(rsp_bus.entered_sleep));
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        idle_cycles = 0;
        seen_req = '{op_e'(req_bus.opcode), req_bus.sensor_slot, req_bus.time_now,
                     req_bus.heater_step_in, req_bus.new_mode, req_bus.new_heater_length,
                     req_bus.new_scan_limit, req_bus.new_sleep_length};
        seen_want = predict_schedule(seen_req);
        pending_results.push_back(drv_pinned ? drv_want : seen_want);
      end
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_bus.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request && !long_hold_done) begin
        rsp_bus.ready = 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        long_hold_done = 1'b1;
      end else if (!allow_gaps) begin
        stall_left = 0;
        rsp_bus.ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        rsp_bus.ready = 1'b0;
      end else begin
        rsp_bus.ready = 1'b1;
      end
    end
  end

  initial begin
    int unsigned      items;
    logic [3:0]       count_val;
    logic [7:0]       gas_val;
    logic [7:0]       offset_val;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgSensorCount;
    cfg_data_i = '0;
    req_bus.valid = 1'b0;
    req_bus.opcode = OpSelect;
    req_bus.sensor_slot = '0;
    req_bus.time_now = '0;
    req_bus.heater_step_in = '0;
    req_bus.new_mode = '0;
    req_bus.new_heater_length = '0;
    req_bus.new_scan_limit = '0;
    req_bus.new_sleep_length = '0;

    // empty table, slots out of range, then a populated table at the extremes
    directed_rows.push_back(pin(req_row(OpSelect, 3'd0, '0, '0, '0, '0, '0, '0), StNone, 4'd0));
    directed_rows.push_back(pin(req_row(OpStep, 3'd5, TimeMax, 8'hFF, '0, '0, '0, '0),
                                StSlot, 4'd5));
    directed_rows.push_back(pin(req_row(OpClear, 3'd0, '0, '0, '0, '0, '0, '0), StSlot, 4'd0));
    directed_rows.push_back(pin(req_row(OpConfig, 3'd0, '0, '0, ModeParallel, 8'd2, 8'd1,
                                        32'd1000), StOk, 4'd0));
    directed_rows.push_back(pin(req_row(OpConfig, 3'd7, TimeMax, 8'hFF, ModeSpare, 8'hFF,
                                        8'hFF, 32'hFFFF_FFFF), StOk, 4'd7));
    directed_rows.push_back(pin(req_row(OpConfig, 3'd1, '0, '0, ModeSleep, 8'd0, 8'd0, 32'd0),
                                StOk, 4'd1));
    directed_rows.push_back(pin(req_row(OpConfig, 3'd2, '0, '0, ModeOther, 8'd1, 8'd3, 32'd50),
                                StOk, 4'd2));
    directed_rows.push_back(pin(req_row(OpConfig, 3'd3, '0, '0, ModeParallel, 8'd3, 8'd2,
                                        32'd0), StOk, 4'd3));
    directed_rows.push_back(cfg_row(CfgSensorCount, 8'hFF));
    directed_rows.push_back(cfg_row(CfgUnused, 8'h00));
    directed_rows.push_back(pin(req_row(OpSelect, 3'd0, '0, '0, '0, '0, '0, '0), StOk, 4'd0));
    directed_rows.push_back(req_row(OpStep, 3'd0, TimeMax, 8'd1, '0, '0, '0, '0));
    directed_rows.push_back(req_row(OpStep, 3'd1, 48'h1234_5678_9ABC, 8'hFF, '0, '0, '0, '0));
    directed_rows.push_back(req_row(OpStep, 3'd3, 48'd100, 8'd0, '0, '0, '0, '0));
    directed_rows.push_back(req_row(OpStep, 3'd2, 48'd7, 8'd0, '0, '0, '0, '0));
    directed_rows.push_back(cfg_row(CfgGasWait, 8'hFF));
    directed_rows.push_back(cfg_row(CfgWakeOffset, 8'h00));
    directed_rows.push_back(pin(req_row(OpSelect, 3'd0, '0, '0, '0, '0, '0, '0), StNone, 4'd8));
    directed_rows.push_back(req_row(OpSelect, 3'd0, TimeMax, '0, '0, '0, '0, '0));
    directed_rows.push_back(cfg_row(CfgWakeOffset, 8'hFF));
    directed_rows.push_back(req_row(OpStep, 3'd3, TimeMax - 48'd5, 8'd1, '0, '0, '0, '0));
    directed_rows.push_back(req_row(OpSelect, 3'd0, 48'd300, '0, '0, '0, '0, '0));
    directed_rows.push_back(pin(req_row(OpClear, 3'd3, TimeMax, 8'hFF, '0, '0, '0, '0),
                                StOk, 4'd3));
    directed_rows.push_back(cfg_row(CfgGasWait, 8'h00));
    directed_rows.push_back(req_row(OpStep, 3'd7, '0, 8'hFE, '0, '0, '0, '0));
    directed_rows.push_back(req_row(OpSelect, 3'd0, 48'h8000_0000_0000, '0, '0, '0, '0, '0));
    directed_rows.push_back(cfg_row(CfgSensorCount, 8'h04));
    directed_rows.push_back(pin(req_row(OpStep, 3'd6, '0, '0, '0, '0, '0, '0), StSlot, 4'd6));
    directed_rows.push_back(pin(req_row(OpClear, 3'd4, '0, '0, '0, '0, '0, '0), StSlot, 4'd4));

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowWrite) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_item(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].want);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      allow_gaps = (p % 4 != 3) && (p < NumPhases - 2);
      count_val = (p == 2) ? 4'd15 : (p == 6) ? 4'd0 : (p % 3 == 0) ? 4'd8 :
                  4'($urandom_range(1, 15));
      gas_val = (p == 1) ? 8'hFF : (p == 3) ? 8'h00 : 8'($urandom);
      offset_val = (p == 1) ? 8'h00 : (p == 4) ? 8'hFF : 8'($urandom);
      write_reg(CfgSensorCount, {4'($urandom), count_val});
      write_reg(CfgGasWait, gas_val);
      write_reg(CfgWakeOffset, offset_val);
      // some phases run close to the 48-bit wrap
      sim_now = ($urandom_range(0, 2) == 0) ? TimeMax - TimeW'($urandom_range(0, 3000))
                                            : {16'($urandom), 32'($urandom)};
      items = (count_val == 0) ? 30 : 105;
      for (int k = 0; k < items; k++) begin
        if (p == 5 && k == 40) hold_request = 1'b1;
        if (p == 8 && k == 50) wait_drained();
        send_item(make_request(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (30) @(negedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/sws_pkg.sv
rtl/sws_req_if.sv
rtl/sws_rsp_if.sv
rtl/sws_ram.sv
rtl/sws_dp.sv
rtl/sws_ctrl.sv
rtl/sensor_wakeup_scheduler.sv
test/sensor_wakeup_scheduler_tb.sv
